// ===== rtl/core/pubsub_message_router_core_assert.svh =====
`ifndef PUBSUB_MESSAGE_ROUTER_CORE_ASSERT_SVH
`define PUBSUB_MESSAGE_ROUTER_CORE_ASSERT_SVH
// Assertion helpers for the router core
`define PMR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("lbl failed");
`define PMR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("lbl failed");
`endif

// ===== rtl/core/pmr_pkg.sv =====
package pmr_pkg;
  localparam int unsigned REQ_BITS    = 2;
  localparam int unsigned STATUS_BITS = 2;

  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_SUB    = 2'd1;
  localparam logic [1:0] REQ_SEND   = 2'd2;
  localparam logic [1:0] REQ_RECV   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAIL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [7:0] BCAST_PIPE = 8'hFF;

  localparam logic [1:0] CFG_PIPE_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_MSGID_LIMIT = 2'd1;
  localparam logic [1:0] CFG_SUBS_LIMIT  = 2'd2;
  localparam logic [1:0] CFG_DEPTH_LIMIT = 2'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture request
    logic check;     // evaluate request, start lookups
    logic rd_sub;    // read subscriber entry at walk index
    logic try_enq;   // attempt enqueue with read subscriber
    logic rd_queue;  // issue queue read (receive)
    logic finish;    // build result
  } pmr_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_walk;   // send needs subscriber walk
    logic is_recv;   // receive with data to pop
    logic walk_last; // current walk index is the last
    logic walk_stop; // unicast match found
  } pmr_stat_t;
endpackage

// ===== rtl/core/pmr_ctrl.sv =====
module pmr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               out_busy,
  input  pmr_pkg::pmr_stat_t stat,
  output pmr_pkg::pmr_cmd_t  cmd,
  output logic               idle
);
  import pmr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RDSUB = 3'd2;
  localparam logic [2:0] S_ENQ   = 3'd3;
  localparam logic [2:0] S_RDQ   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // sequencing of one request
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.load = in_fire;
        if (in_fire) state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.is_walk)      state_next = S_RDSUB;
        else if (stat.is_recv) state_next = S_RDQ;
        else                   state_next = S_DONE;
      end
      S_RDSUB: begin
        cmd.rd_sub = 1'b1;
        state_next = S_ENQ;
      end
      S_ENQ: begin
        cmd.try_enq = 1'b1;
        if (stat.walk_last || stat.walk_stop) state_next = S_DONE;
        else                                  state_next = S_RDSUB;
      end
      S_RDQ: begin
        cmd.rd_queue = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign idle = (state == S_IDLE);
endmodule

// ===== rtl/core/pmr_datapath.sv =====
module pmr_datapath #(
  parameter int unsigned MAX_PIPES    = 16,
  parameter int unsigned MAX_MSG_IDS  = 64,
  parameter int unsigned MAX_SUBS     = 16,
  parameter int unsigned MAX_DEPTH    = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  pmr_pkg::pmr_cmd_t  cmd,
  output pmr_pkg::pmr_stat_t stat,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [6:0]         cfg_data,
  input  logic [1:0]         in_req,
  input  logic [7:0]         in_pipe,
  input  logic [7:0]         in_msg_id,
  input  logic [7:0]         in_depth,
  input  logic [31:0]        in_payload,
  input  logic [15:0]        in_size,
  output logic [1:0]         res_status,
  output logic [3:0]         res_pipe,
  output logic [5:0]         res_msg_id,
  output logic [31:0]        res_payload,
  output logic [15:0]        res_size,
  output logic [4:0]         res_delivered
);
  import pmr_pkg::*;

  localparam int unsigned PW  = (MAX_PIPES > 1) ? $clog2(MAX_PIPES) : 1;
  localparam int unsigned IW  = (MAX_MSG_IDS > 1) ? $clog2(MAX_MSG_IDS) : 1;
  localparam int unsigned SW  = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1;
  localparam int unsigned DW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned PCW = $clog2(MAX_PIPES + 1);
  localparam int unsigned SCW = $clog2(MAX_SUBS + 1);
  localparam int unsigned DCW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned QW  = 8 + PAYLOAD_BITS + 16;

  // configuration registers
  logic [4:0] pipe_limit, subs_limit, depth_limit;
  logic [6:0] msgid_limit;
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_limit  <= 5'd10;
      msgid_limit <= 7'd64;
      subs_limit  <= 5'd10;
      depth_limit <= 5'd10;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_PIPE_LIMIT:  pipe_limit  <= cfg_data[4:0];
        CFG_MSGID_LIMIT: msgid_limit <= cfg_data;
        CFG_SUBS_LIMIT:  subs_limit  <= cfg_data[4:0];
        CFG_DEPTH_LIMIT: depth_limit <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // effective limits, widened to 9 bits
  logic [8:0] eff_pipe, eff_msgid, eff_subs, eff_depth;
  always_comb begin
    eff_pipe  = ({4'd0, pipe_limit} < 9'(MAX_PIPES)) ? {4'd0, pipe_limit} : 9'(MAX_PIPES);
    eff_msgid = ({2'd0, msgid_limit} < 9'(MAX_MSG_IDS)) ? {2'd0, msgid_limit}
                                                         : 9'(MAX_MSG_IDS);
    eff_subs  = ({4'd0, subs_limit} < 9'(MAX_SUBS)) ? {4'd0, subs_limit} : 9'(MAX_SUBS);
    eff_depth = ({4'd0, depth_limit} < 9'(MAX_DEPTH)) ? {4'd0, depth_limit}
                                                       : 9'(MAX_DEPTH);
  end

  // captured request
  logic [1:0]              r_req;
  logic [7:0]              r_pipe, r_id, r_dep;
  logic [PAYLOAD_BITS-1:0] r_pay;
  logic [15:0]             r_size;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_req  <= in_req;
      r_pipe <= in_pipe;
      r_id   <= in_msg_id;
      r_dep  <= in_depth;
      r_pay  <= PAYLOAD_BITS'(in_payload);
      r_size <= in_size;
    end
  end

  // per-pipe state in flops, per-ID counts in a memory
  logic [PCW-1:0] pipes_made;
  logic [7:0]     pipe_depth [MAX_PIPES];
  logic [SCW-1:0] sub_count  [MAX_MSG_IDS];
  logic [MAX_MSG_IDS-1:0] sub_count_vld;
  logic [SCW-1:0] cnt_raw;
  logic           cnt_vld;
  logic [DW-1:0]  queue_head [MAX_PIPES];
  logic [DCW-1:0] queue_fill [MAX_PIPES];

  // memories
  logic [SW+IW-1:0] sub_addr;
  logic [PW-1:0]    sub_rdata_raw;
  logic [7:0]       sub_wdata;
  logic             sub_we;
  logic [PW-1:0]    sub_mem [MAX_MSG_IDS*MAX_SUBS];
  logic [PW+DW-1:0] q_waddr, q_raddr;
  logic             q_we;
  logic [QW-1:0]    q_mem [MAX_PIPES*MAX_DEPTH];
  logic [QW-1:0]    q_rdata;

  logic           id_ok;
  logic [IW-1:0]  idx;
  logic [SCW-1:0] cnt;
  logic [SW-1:0]  walk;
  logic [SCW-1:0] walk_n;
  logic           pn_ok;
  logic [PW-1:0]  pn;
  logic           bcast;
  logic [1:0]     acc_st;
  logic [4:0]     acc_del;
  logic           stop;

  assign id_ok = {1'b0, r_id} < eff_msgid;
  assign idx   = r_id[IW-1:0];
  assign pn    = r_pipe[PW-1:0];
  assign pn_ok = ({1'b0, r_pipe} < eff_pipe) && ({1'b0, r_pipe} < 9'(pipes_made));
  assign bcast = (r_pipe == BCAST_PIPE);
  assign walk_n = (cnt > SCW'(MAX_SUBS)) ? SCW'(MAX_SUBS) : cnt;

  // subscriber counts: read at load, a clear valid bit reads as zero
  always_ff @(posedge clk) begin
    if (sub_we) sub_count[idx] <= cnt + SCW'(1);
    if (cmd.load) cnt_raw <= sub_count[in_msg_id[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_count_vld <= '0;
      cnt_vld       <= 1'b0;
    end else begin
      if (sub_we) sub_count_vld[idx] <= 1'b1;
      if (cmd.load) cnt_vld <= sub_count_vld[in_msg_id[IW-1:0]];
    end
  end

  assign cnt = cnt_vld ? cnt_raw : '0;

  // send walk decision
  logic send_pre, send_walk;
  always_comb begin
    send_pre  = (r_size != 16'd0) && id_ok;
    send_walk = send_pre && (walk_n != '0) &&
                (!bcast || 1'b1) && (!bcast || (9'(cnt) <= eff_subs));
  end

  assign stat.is_walk   = (r_req == REQ_SEND) && send_walk;
  assign stat.is_recv   = (r_req == REQ_RECV) && pn_ok && (queue_fill[pn] != '0);
  assign stat.walk_last = (SCW'(walk) + SCW'(1)) >= walk_n;

  // subscriber memory
  assign sub_addr  = cmd.rd_sub ? {idx, walk} : {idx, cnt[SW-1:0]};
  assign sub_we    = cmd.check && (r_req == REQ_SUB) && id_ok && pn_ok &&
                     (9'(cnt) < eff_subs);
  assign sub_wdata = r_pipe;
  always_ff @(posedge clk) begin
    if (sub_we) sub_mem[sub_addr] <= sub_wdata[PW-1:0];
    sub_rdata_raw <= sub_mem[sub_addr];
  end

  // enqueue target: broadcast uses the read entry, unicast the request pipe
  logic [PW-1:0] tgt;
  logic          tgt_ok, match, enq_ok;
  logic [DCW-1:0] tgt_d;
  logic [DW:0]   slot_sum;
  logic [DW-1:0] slot;
  always_comb begin
    match  = ({{(8-PW){1'b0}}, sub_rdata_raw} == r_pipe);
    tgt    = bcast ? sub_rdata_raw : pn;
    tgt_ok = ({{(9-PW){1'b0}}, tgt} < eff_pipe) &&
             ({{(9-PW){1'b0}}, tgt} < 9'(pipes_made));
    tgt_d  = (pipe_depth[tgt] > 8'(MAX_DEPTH)) ? DCW'(MAX_DEPTH) : DCW'(pipe_depth[tgt]);
    enq_ok = tgt_ok && (queue_fill[tgt] < tgt_d);
    slot_sum = (DW+1)'(queue_head[tgt]) + (DW+1)'(queue_fill[tgt]);
    if (slot_sum >= (DW+1)'(tgt_d)) slot_sum = slot_sum - (DW+1)'(tgt_d);
    slot   = slot_sum[DW-1:0];
  end
  assign stop           = !bcast && match;
  assign stat.walk_stop = stop;

  assign q_we    = cmd.try_enq && (bcast || match) && enq_ok;
  assign q_waddr = {tgt, slot};
  assign q_raddr = {pn, queue_head[pn]};
  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= {r_size, r_pay, r_id};
    if (cmd.rd_queue) q_rdata <= q_mem[q_raddr];
  end

  // state updates
  logic [DCW-1:0] pn_d;
  assign pn_d = (pipe_depth[pn] > 8'(MAX_DEPTH)) ? DCW'(MAX_DEPTH) : DCW'(pipe_depth[pn]);
  logic create_ok;
  assign create_ok = (9'(r_dep) <= eff_depth) && (9'(pipes_made) < eff_pipe);

  always_ff @(posedge clk) begin
    if (rst) begin
      pipes_made <= '0;
      for (int i = 0; i < MAX_PIPES; i++) begin
        queue_head[i] <= '0;
        queue_fill[i] <= '0;
      end
    end else begin
      if (cmd.check && r_req == REQ_CREATE && create_ok) begin
        pipe_depth[pipes_made[PW-1:0]] <= r_dep;
        queue_head[pipes_made[PW-1:0]] <= '0;
        queue_fill[pipes_made[PW-1:0]] <= '0;
        pipes_made <= pipes_made + PCW'(1);
      end
      if (q_we) queue_fill[tgt] <= queue_fill[tgt] + DCW'(1);
      if (cmd.rd_queue) begin
        queue_fill[pn] <= queue_fill[pn] - DCW'(1);
        if ((DCW'(queue_head[pn]) + DCW'(1)) >= pn_d) queue_head[pn] <= '0;
        else queue_head[pn] <= queue_head[pn] + DW'(1);
      end
    end
  end

  // walk index and result accumulation
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      walk    <= '0;
      acc_del <= '0;
      case (r_req)
        REQ_CREATE: acc_st <= create_ok ? ST_OK : ST_FAIL;
        REQ_SUB:    acc_st <= sub_we ? ST_OK : ST_FAIL;
        REQ_SEND:   acc_st <= (send_walk && bcast) ? ST_OK : ST_FAIL;
        default:    acc_st <= !pn_ok ? ST_FAIL :
                              (queue_fill[pn] == '0) ? ST_EMPTY : ST_OK;
      endcase
    end else if (cmd.try_enq) begin
      walk    <= walk + SW'(1);
      if (bcast) begin
        if (enq_ok) acc_del <= acc_del + 5'd1;
        else        acc_st  <= ST_FAIL;
      end else if (match && enq_ok) begin
        acc_del <= 5'd1;
        acc_st  <= ST_OK;
      end
    end
  end

  // result values
  logic rx_ok;
  assign rx_ok = (r_req == REQ_RECV) && (acc_st == ST_OK);
  always_comb begin
    res_status    = acc_st;
    res_pipe      = '0;
    if (r_req == REQ_CREATE && acc_st == ST_OK) res_pipe = 4'(pipes_made - PCW'(1));
    if (r_req == REQ_RECV && acc_st != ST_FAIL) res_pipe = 4'(r_pipe);
    res_msg_id    = rx_ok ? 6'(q_rdata[7:0]) : '0;
    res_payload   = rx_ok ? 32'(q_rdata[8 +: PAYLOAD_BITS]) : '0;
    res_size      = rx_ok ? q_rdata[8+PAYLOAD_BITS +: 16] : '0;
    res_delivered = (r_req == REQ_SEND) ? acc_del : '0;
  end
endmodule

// ===== rtl/core/pubsub_message_router_core.sv =====
// Channel | Dir | Handshake         | Content
// s_axis  | in  | tvalid/tready     | one request item
// m_axis  | out | tvalid/tready     | one result item per request
// cfg     | in  | cfg_we            | register write, no read-back
// Steps: create, subscribe, refused send, receive on empty or missing pipe:
//   check, done; receive with data: check, queue read, done; send: check,
//   then a one-port subscriber memory read and a queue write per entry
//   walked, then done. A unicast send stops at the first matching entry.
// Reset: rst synchronous; clears counters, heads, fills and the FSM; no item
//   is taken while rst is high.
// Stalls: the next request is taken while a result waits in the output
//   register; its own result then waits in the controller until that register
//   is free, and no further request is taken meanwhile.
module pubsub_message_router_core #(
  parameter int unsigned MAX_PIPES    = 16,
  parameter int unsigned MAX_MSG_IDS  = 64,
  parameter int unsigned MAX_SUBS     = 16,
  parameter int unsigned MAX_DEPTH    = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[1:0], pipe_num[9:2], msg_id[17:10], depth[25:18],
  // payload[57:26], payload_size[73:58], zero fill
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], out_pipe[5:2], out_msg_id[11:6], out_payload[43:12],
  // out_size[59:44], delivered[64:60], zero fill
  output logic [71:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [6:0]  cfg_data
);
  import pmr_pkg::*;

  pmr_cmd_t  cmd;
  pmr_stat_t stat;
  logic      idle, in_fire;
  logic [1:0]  res_status;
  logic [3:0]  res_pipe;
  logic [5:0]  res_msg_id;
  logic [31:0] res_payload;
  logic [15:0] res_size;
  logic [4:0]  res_delivered;

  assign s_axis_tready = idle && !rst;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  pmr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(m_axis_tvalid && !m_axis_tready),
    .stat(stat), .cmd(cmd), .idle(idle)
  );

  pmr_datapath #(
    .MAX_PIPES(MAX_PIPES), .MAX_MSG_IDS(MAX_MSG_IDS), .MAX_SUBS(MAX_SUBS),
    .MAX_DEPTH(MAX_DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_req(s_axis_tdata[1:0]), .in_pipe(s_axis_tdata[9:2]),
    .in_msg_id(s_axis_tdata[17:10]), .in_depth(s_axis_tdata[25:18]),
    .in_payload(s_axis_tdata[57:26]), .in_size(s_axis_tdata[73:58]),
    .res_status(res_status), .res_pipe(res_pipe), .res_msg_id(res_msg_id),
    .res_payload(res_payload), .res_size(res_size), .res_delivered(res_delivered)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_axis_tdata <= {7'd0, res_delivered, res_size, res_payload, res_msg_id,
                       res_pipe, res_status};
    end
  end

`include "pubsub_message_router_core_assert.svh"
  `PMR_ASSERT_NXT(a_fin_valid, clk, rst, cmd.finish, m_axis_tvalid)
  `PMR_ASSERT_IMP(a_no_fin_stall, clk, rst, m_axis_tvalid && !m_axis_tready, !cmd.finish)
  `PMR_ASSERT_IMP(a_load_idle, clk, rst, cmd.load, idle)
endmodule

// ===== dv/tb_pubsub_message_router_core.sv =====
module tb_pubsub_message_router_core;
  timeunit 1ns;
  timeprecision 1ps;
  import pmr_pkg::*;

  localparam int NPIPE = 16;
  localparam int NMID  = 64;
  localparam int NSUB  = 16;
  localparam int NDEP  = 16;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  pipe;
    logic [5:0]  mid;
    logic [31:0] payload;
    logic [15:0] size;
    logic [4:0]  delivered;
  } route_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [6:0]  cfg_data = '0;

  pubsub_message_router_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // router state mirror
  int unsigned lim_pipe, lim_mid, lim_subs, lim_depth;
  int unsigned n_pipes;
  int unsigned depth_of [NPIPE];
  int unsigned subs_of  [NMID];
  int unsigned sub_pipe [NMID][NSUB];
  logic [53:0] qmem     [NPIPE][NDEP];
  int unsigned qhead    [NPIPE];
  int unsigned qfill    [NPIPE];

  route_res_t expected_q[$];
  int  errors = 0;
  longint cycles = 0;
  int  hold_cycles = 0;

  function automatic int unsigned emin(int unsigned a, int unsigned b);
    return a < b ? a : b;
  endfunction

  function automatic bit reachable(int unsigned p);
    return p < emin(lim_pipe, NPIPE) && p < n_pipes;
  endfunction

  function automatic bit push_entry(int unsigned p, int unsigned id,
                                    logic [31:0] d, logic [15:0] sz);
    int unsigned dp, slot;
    if (!reachable(p)) return 0;
    dp = emin(depth_of[p], NDEP);
    if (qfill[p] >= dp) return 0;
    slot = qhead[p] + qfill[p];
    if (slot >= dp) slot -= dp;
    qmem[p][slot] = {id[5:0], d, sz};
    qfill[p]++;
    return 1;
  endfunction

  function automatic route_res_t route_request(logic [1:0] req, logic [7:0] pn,
      logic [7:0] id, logic [7:0] dep, logic [31:0] d, logic [15:0] sz);
    route_res_t r;
    int unsigned n, dp;
    r = '0;
    r.status = ST_FAIL;
    case (req)
      REQ_CREATE: begin
        if (dep <= emin(lim_depth, NDEP) && n_pipes < emin(lim_pipe, NPIPE)) begin
          depth_of[n_pipes] = 32'(dep);
          qhead[n_pipes] = 0;
          qfill[n_pipes] = 0;
          r.pipe = 4'(n_pipes);
          n_pipes++;
          r.status = ST_OK;
        end
      end
      REQ_SUB: begin
        if (id < emin(lim_mid, NMID) && reachable(pn) &&
            subs_of[id] < emin(lim_subs, NSUB)) begin
          sub_pipe[id][subs_of[id]] = 32'(pn);
          subs_of[id]++;
          r.status = ST_OK;
        end
      end
      REQ_SEND: begin
        if (sz != 0 && id < emin(lim_mid, NMID)) begin
          n = emin(subs_of[id], NSUB);
          if (pn == BCAST_PIPE) begin
            if (n != 0 && subs_of[id] <= emin(lim_subs, NSUB)) begin
              r.status = ST_OK;
              for (int i = 0; i < n; i++) begin
                if (push_entry(sub_pipe[id][i], id, d, sz)) r.delivered++;
                else r.status = ST_FAIL;
              end
            end
          end else begin
            for (int i = 0; i < n; i++) begin
              if (sub_pipe[id][i] == pn) begin
                if (push_entry(pn, id, d, sz)) begin
                  r.delivered = 5'd1;
                  r.status = ST_OK;
                end
                break;
              end
            end
          end
        end
      end
      default: begin
        if (reachable(pn)) begin
          r.pipe = 4'(pn);
          if (qfill[pn] == 0) begin
            r.status = ST_EMPTY;
          end else begin
            dp = emin(depth_of[pn], NDEP);
            {r.mid, r.payload, r.size} = qmem[pn][qhead[pn]];
            qhead[pn]++;
            if (qhead[pn] >= dp) qhead[pn] = 0;
            qfill[pn]--;
            r.status = ST_OK;
          end
        end
      end
    endcase
    return r;
  endfunction

  // sender: one item per call, random gap before it; valid stays up between
  // back-to-back items
  task automatic send_req(logic [1:0] req, logic [7:0] pn, logic [7:0] id,
                          logic [7:0] dep, logic [31:0] d, logic [15:0] sz);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    expected_q.push_back(route_request(req, pn, id, dep, d, sz));
    s_axis_tdata <= {6'd0, sz, d, dep, id, pn, req};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_PIPE_LIMIT:  lim_pipe  = 32'(val[4:0]);
      CFG_MSGID_LIMIT: lim_mid   = 32'(val);
      CFG_SUBS_LIMIT:  lim_subs  = 32'(val[4:0]);
      default:         lim_depth = 32'(val[4:0]);
    endcase
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
    end
  end

  // result check
  always @(posedge clk) begin
    route_res_t got, exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status    = m_axis_tdata[1:0];
      got.pipe      = m_axis_tdata[5:2];
      got.mid       = m_axis_tdata[11:6];
      got.payload   = m_axis_tdata[43:12];
      got.size      = m_axis_tdata[59:44];
      got.delivered = m_axis_tdata[64:60];
      if (expected_q.size() == 0) begin
        $error("unexpected result item %h", got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
        end
        if (got.pipe !== exp_r.pipe) begin
          $error("out_pipe exp %0d got %0d", exp_r.pipe, got.pipe); errors++;
        end
        if (got.mid !== exp_r.mid) begin
          $error("out_msg_id exp %0d got %0d", exp_r.mid, got.mid); errors++;
        end
        if (got.payload !== exp_r.payload) begin
          $error("out_payload exp %h got %h", exp_r.payload, got.payload); errors++;
        end
        if (got.size !== exp_r.size) begin
          $error("out_size exp %0d got %0d", exp_r.size, got.size); errors++;
        end
        if (got.delivered !== exp_r.delivered) begin
          $error("delivered exp %0d got %0d", exp_r.delivered, got.delivered);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [7:0] pick_pipe();
    return ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 17));
  endfunction

  function automatic logic [7:0] pick_id();
    return ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
  endfunction

  function automatic logic [15:0] pick_size();
    return ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
  endfunction

  // directed: extremes, refusals, depth zero, broadcast partial, empty receive
  task automatic test_directed();
    send_req(REQ_RECV, 8'd0, 8'd0, 8'd0, '0, 16'd0);
    send_req(REQ_CREATE, 8'd0, 8'd0, 8'd11, '0, 16'd0);
    send_req(REQ_CREATE, 8'd0, 8'd0, 8'd0, '0, 16'd0);
    send_req(REQ_CREATE, 8'd0, 8'd0, 8'd1, '0, 16'd0);
    send_req(REQ_CREATE, 8'hFF, 8'hFF, 8'd10, '0, 16'd0);
    send_req(REQ_SUB, 8'd0, 8'd3, 8'd0, '0, 16'd0);
    send_req(REQ_SUB, 8'd1, 8'd3, 8'd0, '0, 16'd0);
    send_req(REQ_SUB, 8'd1, 8'd3, 8'd0, '0, 16'd0);
    send_req(REQ_SUB, 8'd2, 8'd3, 8'd0, '0, 16'd0);
    send_req(REQ_SUB, 8'd9, 8'd3, 8'd0, '0, 16'd0);
    send_req(REQ_SUB, 8'd2, 8'd64, 8'd0, '0, 16'd0);
    send_req(REQ_SEND, BCAST_PIPE, 8'd3, 8'd0, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(REQ_SEND, 8'd2, 8'd3, 8'd0, 32'h0, 16'd1);
    send_req(REQ_SEND, 8'd2, 8'd3, 8'd0, 32'h1234_5678, 16'd0);
    send_req(REQ_SEND, 8'd2, 8'd255, 8'hFF, 32'h5555_AAAA, 16'd7);
    send_req(REQ_SEND, BCAST_PIPE, 8'd5, 8'd0, 32'h1, 16'd1);
    send_req(REQ_SEND, 8'd1, 8'd4, 8'd0, 32'h1, 16'd1);
    send_req(REQ_RECV, 8'd1, 8'd0, 8'd0, '0, 16'd0);
    send_req(REQ_RECV, 8'd1, 8'd0, 8'd0, '0, 16'd0);
    send_req(REQ_RECV, 8'd2, 8'd0, 8'd0, '0, 16'd0);
    send_req(REQ_RECV, 8'd2, 8'd0, 8'd0, '0, 16'd0);
    send_req(REQ_RECV, 8'd0, 8'd0, 8'd0, '0, 16'd0);
    send_req(REQ_RECV, 8'hFF, 8'd0, 8'd0, '0, 16'd0);
  endtask

  // mostly well-formed traffic on a few IDs and the live pipes
  task automatic test_random(int n);
    int k;
    logic [1:0] req;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 8) req = REQ_CREATE;
      else if (k < 25) req = REQ_SUB;
      else if (k < 60) req = REQ_SEND;
      else req = REQ_RECV;
      send_req(req, (req == REQ_SEND && $urandom_range(0, 2) == 0) ? BCAST_PIPE : pick_pipe(),
               pick_id(),
               ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 17)),
               32'($urandom), pick_size());
    end
  endtask

  // receiver holds off while the sender keeps pushing
  task automatic test_backpressure();
    hold_cycles = 300;
    test_random(40);
  endtask

  task automatic test_limits();
    drain();
    write_reg(CFG_PIPE_LIMIT, 7'd16);
    write_reg(CFG_DEPTH_LIMIT, 7'd16);
    write_reg(CFG_SUBS_LIMIT, 7'd16);
    write_reg(CFG_MSGID_LIMIT, 7'd127);
    for (int i = 0; i < 8; i++)
      send_req(REQ_CREATE, 8'd0, 8'd0, 8'($urandom_range(0, 16)), '0, 16'd0);
    for (int i = 0; i < 18; i++)
      send_req(REQ_SUB, 8'($urandom_range(0, 15)), 8'd63, 8'd0, '0, 16'd0);
    send_req(REQ_SEND, BCAST_PIPE, 8'd63, 8'd0, 32'($urandom), 16'd3);
    test_random(400);
    drain();
    // lowered limits: unreachable pipes and over-long lists
    write_reg(CFG_PIPE_LIMIT, 7'd4);
    write_reg(CFG_SUBS_LIMIT, 7'd2);
    write_reg(CFG_MSGID_LIMIT, 7'd5);
    write_reg(CFG_DEPTH_LIMIT, 7'd0);
    send_req(REQ_SEND, BCAST_PIPE, 8'd63, 8'd0, 32'h1, 16'd1);
    test_random(300);
    drain();
    write_reg(CFG_PIPE_LIMIT, 7'd0);
    write_reg(CFG_SUBS_LIMIT, 7'd0);
    write_reg(CFG_MSGID_LIMIT, 7'd0);
    test_random(60);
    drain();
    write_reg(CFG_PIPE_LIMIT, 7'd31);
    write_reg(CFG_SUBS_LIMIT, 7'd31);
    write_reg(CFG_MSGID_LIMIT, 7'd64);
    write_reg(CFG_DEPTH_LIMIT, 7'd31);
    test_random(400);
  endtask

  initial begin
    lim_pipe = 10; lim_mid = 64; lim_subs = 10; lim_depth = 10;
    n_pipes = 0;
    foreach (subs_of[i]) subs_of[i] = 0;
    foreach (qhead[i]) begin
      qhead[i] = 0;
      qfill[i] = 0;
      depth_of[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_backpressure();
    drain();
    test_limits();
    drain();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== pubsub_message_router_core.f =====
+incdir+rtl/core
rtl/core/pmr_pkg.sv
rtl/core/pmr_ctrl.sv
rtl/core/pmr_datapath.sv
rtl/core/pubsub_message_router_core.sv
dv/tb_pubsub_message_router_core.sv
